[rtl/core/rfl_pkg.sv]
// ----------------------------------------------------------------------------
// rfl_pkg: shared types and constants for the ring free-list ID allocator
// Default pool size, ID width, command codes and the slot memory control word.
// ----------------------------------------------------------------------------
package rfl_pkg;

	// default number of IDs in the pool
	localparam int unsigned CAPACITY_DEF = 255;

	// width of an ID and of the output count
	localparam int unsigned ID_W = 8;

	// request codes
	typedef enum logic [0:0] {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	// slot memory strobes
	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

endpackage

[rtl/core/rfl_slot_ram.sv]
// ----------------------------------------------------------------------------
// rfl_slot_ram: single-port slot memory of the ID ring
// One write and one registered read per cycle at a shared address; a read
// and write at the same address in one cycle returns the old contents.
// ----------------------------------------------------------------------------
module rfl_slot_ram #(
	parameter int unsigned DEPTH = rfl_pkg::CAPACITY_DEF + 1,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  rfl_pkg::ram_ctl_t         ctl,
	input  logic [AW-1:0]             addr,
	input  logic [rfl_pkg::ID_W-1:0]  wdata,
	output logic [rfl_pkg::ID_W-1:0]  rdata
);

	logic [rfl_pkg::ID_W-1:0] mem [DEPTH];
	logic [rfl_pkg::ID_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;

endmodule

[rtl/core/rfl_ctrl.sv]
// ----------------------------------------------------------------------------
// rfl_ctrl: ring positions, free count and result register
// Runs the post-reset fill sweep, serves one request per accepted word and
// holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module rfl_ctrl #(
	parameter int unsigned CAPACITY = rfl_pkg::CAPACITY_DEF,
	parameter int unsigned AW       = $clog2(CAPACITY + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [rfl_pkg::ID_W-1:0]  release_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic                      grant,
	output logic [rfl_pkg::ID_W-1:0]  free_count,
	output rfl_pkg::ram_ctl_t         ram_ctl,
	output logic [AW-1:0]             ram_addr,
	output logic [rfl_pkg::ID_W-1:0]  ram_wdata
);

	localparam logic [AW-1:0] LAST = AW'(CAPACITY);

	logic          init_q;
	logic [AW-1:0] init_idx_q;
	logic [AW-1:0] fetch_q;
	logic [AW-1:0] return_q;
	logic [AW-1:0] count_q;
	logic          out_valid_q;
	logic          ok_q;
	logic          grant_q;

	logic          acc;
	logic          is_rel;
	logic          alloc_ok;
	logic          rel_ok;
	logic [AW-1:0] fetch_nxt;
	logic [AW-1:0] return_nxt;
	logic [AW+rfl_pkg::ID_W-1:0] idx_ext;
	logic [AW+rfl_pkg::ID_W-1:0] cnt_ext;

	// handshake
	assign in_stall = init_q || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign is_rel   = (rfl_pkg::cmd_t'(command) == rfl_pkg::CMD_RELEASE);

	// pool status and ring advance
	assign alloc_ok   = (count_q != '0);
	assign rel_ok     = (count_q != LAST);
	assign fetch_nxt  = (fetch_q == LAST) ? '0 : fetch_q + 1'b1;
	assign return_nxt = (return_q == LAST) ? '0 : return_q + 1'b1;

	// zero-extend before taking the low ID bits
	assign idx_ext = {{rfl_pkg::ID_W{1'b0}}, init_idx_q};
	assign cnt_ext = {{rfl_pkg::ID_W{1'b0}}, count_q};

	// slot memory access
	always_comb begin
		ram_ctl   = '0;
		ram_addr  = fetch_q;
		ram_wdata = '0;
		if (init_q) begin
			ram_ctl.we = 1'b1;
			ram_addr   = init_idx_q;
			ram_wdata  = idx_ext[rfl_pkg::ID_W-1:0];
		end else if (acc) begin
			if (is_rel) begin
				ram_ctl.we = rel_ok;
				ram_addr   = return_q;
				ram_wdata  = release_id;
			end else begin
				// read the ID and clear the slot in one access
				ram_ctl.we = alloc_ok;
				ram_ctl.re = alloc_ok;
			end
		end
	end

	// fill sweep after reset: slot k gets k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			init_idx_q <= '0;
		end else if (init_q) begin
			init_idx_q <= init_idx_q + 1'b1;
			if (init_idx_q == LAST) begin
				init_q <= 1'b0;
			end
		end
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q  <= (LAST == '0) ? '0 : AW'(1);
			return_q <= '0;
			count_q  <= LAST;
		end else if (acc) begin
			if (is_rel) begin
				if (rel_ok) begin
					return_q <= return_nxt;
					count_q  <= count_q + 1'b1;
				end
			end else if (alloc_ok) begin
				fetch_q <= fetch_nxt;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			grant_q     <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
			ok_q        <= is_rel ? rel_ok : alloc_ok;
			grant_q     <= !is_rel && alloc_ok;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = ok_q;
	assign grant      = grant_q;
	// count only moves on an accepted word, so it matches the held result
	assign free_count = cnt_ext[rfl_pkg::ID_W-1:0];

endmodule

[rtl/core/ring_free_list_id_allocator_unit.sv]
// ----------------------------------------------------------------------------
// ring_free_list_id_allocator_unit: circular free-list ID allocator
// Hands out and takes back IDs from a ring of CAPACITY+1 slots.
// ----------------------------------------------------------------------------
// Each request word (allocate or release) gets a registered result, which
// appears on the output in the cycle after the word is accepted, and a
// new word can be accepted every cycle while the output is being taken. The
// rate is set by the single-port slot memory, which sees one access per
// request (allocate reads the ID and clears its slot in the same access).
// After reset the block fills the slot memory with its start contents,
// one slot per cycle, holding in_stall high until the sweep is done.
module ring_free_list_id_allocator_unit #(
	parameter int unsigned CAPACITY = rfl_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [rfl_pkg::ID_W-1:0]  release_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [rfl_pkg::ID_W-1:0]  granted_id,
	output logic                      accepted,
	output logic [rfl_pkg::ID_W-1:0]  free_count
);

	localparam int unsigned DEPTH = CAPACITY + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	rfl_pkg::ram_ctl_t        ram_ctl;
	logic [AW-1:0]            ram_addr;
	logic [rfl_pkg::ID_W-1:0] ram_wdata;
	logic [rfl_pkg::ID_W-1:0] ram_rdata;
	logic                     grant;

	// control and result register
	rfl_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.grant      (grant),
		.free_count (free_count),
		.ram_ctl    (ram_ctl),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata)
	);

	// slot ring
	rfl_slot_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// released and failed words report no ID
	assign granted_id = grant ? ram_rdata : '0;

endmodule

[rtl/core/rfl_checker.sv]
// ----------------------------------------------------------------------------
// rfl_checker: port-level checks for the ID allocator
// Latency, held results and free count bookkeeping as seen on the ports.
// ----------------------------------------------------------------------------
module rfl_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      command,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [rfl_pkg::ID_W-1:0]  granted_id,
	input logic                      accepted,
	input logic [rfl_pkg::ID_W-1:0]  free_count
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_id)
			&& $stable(accepted) && $stable(free_count))
		else $error("stalled result changed");

	// every accepted word gives a result the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("result missing after accepted word");

	// a refused request hands out no ID
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> granted_id == '0)
		else $error("ID granted on refused request");

	// a successful release adds one free ID
	a_rel_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command
			|=> !accepted || free_count == $past(free_count) + 8'd1)
		else $error("free count wrong after release");

	// a successful allocate removes one free ID
	a_alloc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !command
			|=> !accepted || free_count == $past(free_count) - 8'd1)
		else $error("free count wrong after allocate");

endmodule

bind ring_free_list_id_allocator_unit rfl_checker u_rfl_checker (.*);
